### hw/rtl/bff2d_pkg.sv
// Package for the boundary filter fold block: widths, register indexes,
// microcode field types and the control and status structs.
// Depends on nothing; every other file of the block imports it.
package bff2d_pkg;

	// Payload widths.
	localparam int COEF_W  = 32;
	localparam int VALUE_W = 40;
	localparam int POS_W   = 3;
	localparam int IDX_W   = 6;

	// Configuration register indexes.
	localparam logic [2:0] REG_HALF_WIDTH   = 3'd0;
	localparam logic [2:0] REG_FOLD_LEFT    = 3'd1;
	localparam logic [2:0] REG_FOLD_LOWER   = 3'd2;
	localparam logic [2:0] REG_COLS_OUTSIDE = 3'd3;
	localparam logic [2:0] REG_ROWS_OUTSIDE = 3'd4;

	// Program addresses of the microcode.
	typedef enum logic [3:0] {
		P_LOAD, P_CHECK, P_PASS, P_RD_A, P_RD_B, P_GET_B, P_RD_V, P_MAC,
		P_WR_A, P_WR_B, P_PASS_END, P_EMIT_INIT, P_EMIT_RD, P_EMIT_OUT,
		P_DONE, P_BAD
	} ustep_t;

	// Conditions the sequencer can wait on or branch on.
	typedef enum logic [3:0] {
		C_ALWAYS, C_NEVER, C_IN_VALID, C_OUT_FREE, C_LOAD_MORE, C_BAD,
		C_NO_FOLD, C_DIST_MORE, C_LINE_MORE, C_PASS_COL, C_EMIT_MORE
	} cond_t;

	typedef enum logic [2:0] {RD_NONE, RD_A, RD_B, RD_V, RD_EMIT} rd_sel_t;
	typedef enum logic [1:0] {ACC_NONE, ACC_LOAD_A, ACC_LOAD_B, ACC_MAC} acc_op_t;
	typedef enum logic [1:0] {WR_NONE, WR_COEF, WR_A, WR_B} wr_op_t;
	typedef enum logic [2:0] {
		CNT_NONE, CNT_LOAD, CNT_PASS_COL, CNT_DIST_INC, CNT_LINE_INC,
		CNT_PASS_ROW, CNT_EMIT_INIT, CNT_EMIT_INC
	} cnt_op_t;

	// One control word of the program.
	typedef struct packed {
		cond_t   wait_c;
		cond_t   jmp_c;
		ustep_t  jmp_to;
		logic    in_rdy;
		rd_sel_t rd;
		acc_op_t acc;
		wr_op_t  wr;
		cnt_op_t cnt;
		logic    out_load;
		logic    out_bad;
	} uword_t;

	// Datapath commands for the current cycle.
	typedef struct packed {
		logic    go;
		logic    in_rdy;
		rd_sel_t rd;
		acc_op_t acc;
		wr_op_t  wr;
		cnt_op_t cnt;
		logic    out_load;
		logic    out_bad;
	} op_t;

	// Flags the datapath reports back to the sequencer.
	typedef struct packed {
		logic out_free;
		logic load_more;
		logic bad;
		logic no_fold;
		logic dist_more;
		logic line_more;
		logic pass_col;
		logic emit_more;
	} stat_t;

	// Configuration register set.
	typedef struct packed {
		logic [1:0] half_width;
		logic       fold_left;
		logic       fold_lower;
		logic [1:0] cols_outside;
		logic [1:0] rows_outside;
	} cfg_t;

endpackage

### hw/rtl/bff2d_useq.sv
// Microcode sequencer: program ROM, step counter, wait and branch logic.
// Depends on bff2d_pkg; drives the datapath through an op_t word.
module bff2d_useq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  bff2d_pkg::stat_t  stat,
	output bff2d_pkg::op_t    op
);
	import bff2d_pkg::*;

	ustep_t step_q;
	ustep_t step_nxt;
	uword_t uw;
	logic   go;

	// Program ROM: one control word per step.
	function automatic uword_t ucode(input ustep_t s);
		uword_t w;
		w = '{wait_c: C_ALWAYS, jmp_c: C_NEVER, jmp_to: P_LOAD, in_rdy: 1'b0,
			rd: RD_NONE, acc: ACC_NONE, wr: WR_NONE, cnt: CNT_NONE,
			out_load: 1'b0, out_bad: 1'b0};
		unique case (s)
			P_LOAD: begin
				w.wait_c = C_IN_VALID; w.in_rdy = 1'b1; w.wr = WR_COEF;
				w.cnt = CNT_LOAD; w.jmp_c = C_LOAD_MORE; w.jmp_to = P_LOAD;
			end
			P_CHECK: begin
				w.cnt = CNT_PASS_COL; w.jmp_c = C_BAD; w.jmp_to = P_BAD;
			end
			P_PASS: begin
				w.jmp_c = C_NO_FOLD; w.jmp_to = P_PASS_END;
			end
			P_RD_A: w.rd = RD_A;
			P_RD_B: begin
				w.rd = RD_B; w.acc = ACC_LOAD_A;
			end
			P_GET_B: w.acc = ACC_LOAD_B;
			P_RD_V: w.rd = RD_V;
			P_MAC: begin
				w.acc = ACC_MAC; w.cnt = CNT_DIST_INC;
				w.jmp_c = C_DIST_MORE; w.jmp_to = P_RD_V;
			end
			P_WR_A: w.wr = WR_A;
			P_WR_B: begin
				w.wr = WR_B; w.cnt = CNT_LINE_INC;
				w.jmp_c = C_LINE_MORE; w.jmp_to = P_RD_A;
			end
			P_PASS_END: begin
				w.cnt = CNT_PASS_ROW; w.jmp_c = C_PASS_COL; w.jmp_to = P_PASS;
			end
			P_EMIT_INIT: w.cnt = CNT_EMIT_INIT;
			P_EMIT_RD: w.rd = RD_EMIT;
			P_EMIT_OUT: begin
				w.wait_c = C_OUT_FREE; w.out_load = 1'b1; w.cnt = CNT_EMIT_INC;
				w.jmp_c = C_EMIT_MORE; w.jmp_to = P_EMIT_RD;
			end
			P_DONE: begin
				w.jmp_c = C_ALWAYS; w.jmp_to = P_LOAD;
			end
			P_BAD: begin
				w.wait_c = C_OUT_FREE; w.out_load = 1'b1; w.out_bad = 1'b1;
				w.jmp_c = C_ALWAYS; w.jmp_to = P_LOAD;
			end
		endcase
		return w;
	endfunction

	// Condition select.
	function automatic logic cond_met(input cond_t c, input stat_t st, input logic iv);
		logic r;
		unique case (c)
			C_ALWAYS:    r = 1'b1;
			C_NEVER:     r = 1'b0;
			C_IN_VALID:  r = iv;
			C_OUT_FREE:  r = st.out_free;
			C_LOAD_MORE: r = st.load_more;
			C_BAD:       r = st.bad;
			C_NO_FOLD:   r = st.no_fold;
			C_DIST_MORE: r = st.dist_more;
			C_LINE_MORE: r = st.line_more;
			C_PASS_COL:  r = st.pass_col;
			C_EMIT_MORE: r = st.emit_more;
			default:     r = 1'b0;
		endcase
		return r;
	endfunction

	// Control word outputs of the current step.
	always_comb begin
		uw          = ucode(step_q);
		go          = cond_met(uw.wait_c, stat, in_valid);
		op.go       = go;
		op.in_rdy   = uw.in_rdy;
		op.rd       = uw.rd;
		op.acc      = uw.acc;
		op.wr       = uw.wr;
		op.cnt      = uw.cnt;
		op.out_load = uw.out_load;
		op.out_bad  = uw.out_bad;
	end

	// Next step: hold while waiting, branch when taken, else advance.
	always_comb begin
		if (!go) begin
			step_nxt = step_q;
		end else if (cond_met(uw.jmp_c, stat, in_valid)) begin
			step_nxt = uw.jmp_to;
		end else begin
			step_nxt = ustep_t'(4'(step_q) + 4'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= P_LOAD;
		end else begin
			step_q <= step_nxt;
		end
	end

endmodule

### hw/rtl/bff2d_dpath.sv
// Datapath: coefficient memory, address generation, loop counters, fold
// accumulators and the output register. Depends on bff2d_pkg.
module bff2d_dpath #(
	parameter int MAX_HALF = 3
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  bff2d_pkg::op_t                     op,
	input  bff2d_pkg::cfg_t                    cfg,
	input  logic signed [bff2d_pkg::COEF_W-1:0] coef,
	input  logic                               out_ready,
	output bff2d_pkg::stat_t                   stat,
	output logic                               out_valid,
	output logic signed [bff2d_pkg::VALUE_W-1:0] out_value,
	output logic                               out_last,
	output logic                               out_bad
);
	import bff2d_pkg::*;

	localparam int MAX_SIDE = 2 * MAX_HALF + 1;
	localparam int DEPTH    = MAX_SIDE * MAX_SIDE;
	localparam int AW       = $clog2(DEPTH);

	// Coefficient store and its registered read port.
	logic [VALUE_W-1:0] mem [DEPTH];
	logic [VALUE_W-1:0] rdata_q;

	// Loop counters.
	logic [IDX_W-1:0] load_idx_q;
	logic             pass_q;
	logic [POS_W-1:0] line_q;
	logic [1:0]       dist_q;
	logic [POS_W-1:0] em_r_q, em_c_q;

	// Accumulators and output register.
	logic [VALUE_W-1:0] acc_a_q, acc_b_q;
	logic               out_valid_q, out_last_q, out_bad_q;
	logic [VALUE_W-1:0] out_value_q;

	// Derived geometry.
	logic [POS_W-1:0] side;
	logic [5:0]       side_sq;
	logic [IDX_W:0]   total;
	logic             load_done;
	logic [1:0]       kp;
	logic             fwd;
	logic [POS_W-1:0] pos_a, pos_b, pos_v;
	logic [AW-1:0]    addr_a, addr_b, addr_v, addr_e, rd_addr, wr_addr;
	logic [VALUE_W-1:0] wr_data;
	logic             wr_en;
	logic [POS_W-1:0] c_lo, c_hi, r_lo, r_hi;
	logic             bad;
	logic [VALUE_W-1:0] dv;

	function automatic logic [AW-1:0] lin_addr(input logic [POS_W-1:0] row,
		input logic [POS_W-1:0] col, input logic [POS_W-1:0] s);
		logic [5:0] a;
		a = 6'(row) * 6'(s) + 6'(col);
		return a[AW-1:0];
	endfunction

	// Side, element count and load completion.
	always_comb begin
		side    = {cfg.half_width, 1'b1};
		side_sq = 6'(side) * 6'(side);
		total   = (7'(side_sq) > 7'(DEPTH)) ? 7'(DEPTH) : 7'(side_sq);
		load_done = (7'(load_idx_q) + 7'd1) >= total;
		bad = (cfg.half_width == 2'd0) || (32'(cfg.half_width) > 32'(MAX_HALF))
			|| (cfg.cols_outside > cfg.half_width)
			|| (cfg.rows_outside > cfg.half_width);
	end

	// Fold positions along the current line: target A, target B, source V.
	always_comb begin
		kp  = pass_q ? cfg.rows_outside : cfg.cols_outside;
		fwd = pass_q ? cfg.fold_lower : cfg.fold_left;
		if (fwd) begin
			pos_a = 3'(kp);
			pos_b = 3'(kp) + 3'd1;
			pos_v = 3'(kp) - 3'(dist_q);
		end else begin
			pos_a = side - 3'd1 - 3'(kp);
			pos_b = side - 3'd2 - 3'(kp);
			pos_v = side - 3'd1 - 3'(kp) + 3'(dist_q);
		end
		if (pass_q) begin
			addr_a = lin_addr(pos_a, line_q, side);
			addr_b = lin_addr(pos_b, line_q, side);
			addr_v = lin_addr(pos_v, line_q, side);
		end else begin
			addr_a = lin_addr(line_q, pos_a, side);
			addr_b = lin_addr(line_q, pos_b, side);
			addr_v = lin_addr(line_q, pos_v, side);
		end
		addr_e = lin_addr(em_r_q, em_c_q, side);
	end

	// Cropped window bounds.
	always_comb begin
		c_lo = cfg.fold_left ? 3'(cfg.cols_outside) : 3'd0;
		c_hi = cfg.fold_left ? side - 3'd1 : side - 3'd1 - 3'(cfg.cols_outside);
		r_lo = cfg.fold_lower ? 3'(cfg.rows_outside) : 3'd0;
		r_hi = cfg.fold_lower ? side - 3'd1 : side - 3'd1 - 3'(cfg.rows_outside);
	end

	// Status back to the sequencer.
	always_comb begin
		stat.out_free  = !out_valid_q || out_ready;
		stat.load_more = !load_done;
		stat.bad       = bad;
		stat.no_fold   = (kp == 2'd0);
		stat.dist_more = (dist_q != kp);
		stat.line_more = (line_q != side - 3'd1);
		stat.pass_col  = !pass_q;
		stat.emit_more = !((em_r_q == r_hi) && (em_c_q == c_hi));
	end

	// Read address select.
	always_comb begin
		unique case (op.rd)
			RD_A:    rd_addr = addr_a;
			RD_B:    rd_addr = addr_b;
			RD_V:    rd_addr = addr_v;
			RD_EMIT: rd_addr = addr_e;
			default: rd_addr = addr_e;
		endcase
	end

	// Write port select; a coefficient beyond the current size is dropped.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = addr_a;
		wr_data = acc_a_q;
		unique case (op.wr)
			WR_COEF: begin
				wr_en   = op.go && (7'(load_idx_q) < total);
				wr_addr = load_idx_q[AW-1:0];
				wr_data = VALUE_W'(coef);
			end
			WR_A: begin
				wr_en = op.go;
			end
			WR_B: begin
				wr_en   = op.go;
				wr_addr = addr_b;
				wr_data = acc_b_q;
			end
			default: wr_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (op.go && (op.rd != RD_NONE)) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// Fold step: A gains (d+1)*v and B loses d*v, by shift and add.
	always_comb begin
		dv = (dist_q[0] ? rdata_q : '0) + (dist_q[1] ? {rdata_q[VALUE_W-2:0], 1'b0} : '0);
	end

	always_ff @(posedge clk) begin
		if (op.go) begin
			unique case (op.acc)
				ACC_LOAD_A: acc_a_q <= rdata_q;
				ACC_LOAD_B: acc_b_q <= rdata_q;
				ACC_MAC: begin
					acc_a_q <= acc_a_q + dv + rdata_q;
					acc_b_q <= acc_b_q - dv;
				end
				default: ;
			endcase
		end
	end

	// Loop counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_idx_q <= '0;
			pass_q     <= 1'b0;
			line_q     <= '0;
			dist_q     <= 2'd1;
			em_r_q     <= '0;
			em_c_q     <= '0;
		end else if (op.go) begin
			unique case (op.cnt)
				CNT_LOAD: load_idx_q <= load_done ? '0 : load_idx_q + 6'd1;
				CNT_PASS_COL: begin
					pass_q <= 1'b0; line_q <= '0; dist_q <= 2'd1;
				end
				CNT_PASS_ROW: begin
					pass_q <= 1'b1; line_q <= '0; dist_q <= 2'd1;
				end
				CNT_DIST_INC: dist_q <= dist_q + 2'd1;
				CNT_LINE_INC: begin
					line_q <= line_q + 3'd1; dist_q <= 2'd1;
				end
				CNT_EMIT_INIT: begin
					em_r_q <= r_lo; em_c_q <= c_lo;
				end
				CNT_EMIT_INC: begin
					if (em_c_q == c_hi) begin
						em_c_q <= c_lo;
						em_r_q <= em_r_q + 3'd1;
					end else begin
						em_c_q <= em_c_q + 3'd1;
					end
				end
				default: ;
			endcase
		end
	end

	// Output register: filled by the sequencer, drained by the consumer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (op.go && op.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (op.go && op.out_load) begin
			out_value_q <= op.out_bad ? '0 : rdata_q;
			out_last_q  <= op.out_bad || !stat.emit_more;
			out_bad_q   <= op.out_bad;
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign out_last  = out_last_q;
	assign out_bad   = out_bad_q;

endmodule

### hw/rtl/boundary_filter_fold_2d_top.sv
// Top level of the boundary filter fold block: ports, configuration
// registers, sequencer and datapath. Depends on bff2d_pkg, bff2d_useq, bff2d_dpath.
//
// Channel  | Direction | Word                      | Handshake
// s_axis   | in        | tdata: coef [31:0]        | tvalid / tready
// m_axis   | out       | tdata: value [39:0],      | tvalid / tready
//          |           | tlast: last_value,        |
//          |           | tuser: bad_setting        |
// cfg      | in        | cfg_index, cfg_data       | cfg_valid / cfg_ready
//
// Coefficients are taken while the program sits in its load step. After the
// last coefficient a bad setting gives one error word; else the program folds
// the outside elements of each line, side 2m+1 lines per pass, column pass then
// row pass, and emits each result through the single read port of the memory.
// Reset sets the step counter, loop counters, output valid and configuration
// to their initial values. A stalled output word holds the program in its
// emit step; loading resumes once the done step after the final word is past.
module boundary_filter_fold_2d_top #(
	parameter int MAX_HALF = 3
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic signed [31:0] s_axis_tdata,   // [31:0] coef
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic signed [39:0] m_axis_tdata,   // [39:0] value
	output logic               m_axis_tlast,
	output logic               m_axis_tuser,   // [0] bad_setting
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [1:0]         cfg_data
);
	import bff2d_pkg::*;

	cfg_t  cfg_q;
	op_t   op;
	stat_t stat;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{half_width: 2'd1, fold_left: 1'b1, fold_lower: 1'b1,
				cols_outside: 2'd0, rows_outside: 2'd0};
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_HALF_WIDTH:   cfg_q.half_width   <= cfg_data;
				REG_FOLD_LEFT:    cfg_q.fold_left    <= cfg_data[0];
				REG_FOLD_LOWER:   cfg_q.fold_lower   <= cfg_data[0];
				REG_COLS_OUTSIDE: cfg_q.cols_outside <= cfg_data;
				REG_ROWS_OUTSIDE: cfg_q.rows_outside <= cfg_data;
				default: ;
			endcase
		end
	end

	// Program sequencer.
	bff2d_useq u_useq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.stat     (stat),
		.op       (op)
	);

	// Memory, counters, accumulators and output register.
	bff2d_dpath #(
		.MAX_HALF (MAX_HALF)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.cfg       (cfg_q),
		.coef      (s_axis_tdata),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.out_valid (m_axis_tvalid),
		.out_value (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.out_bad   (m_axis_tuser)
	);

	assign s_axis_tready = op.in_rdy;

	// An error word is always a single, final word with no data.
	a_bad_word: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && (m_axis_tdata == '0)))
		else $error("error word without last flag or with data");

	// The word that completes a filter stops input until processing is over.
	a_load_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && !stat.load_more) |=> !s_axis_tready)
		else $error("input still accepted after the filter was complete");

endmodule
